// ===== rtl/b2a_pkg.sv =====
// Shared constants and the BCD adjust function of the binary to ASCII decimal converter.
package b2a_pkg;

	// Width of the binary input field.
	localparam int NUMBER_W = 40;

	// Decimal digits needed to hold any 40-bit value, and their packed width.
	localparam int BCD_NIBBLES = 13;
	localparam int BCD_W       = 4 * BCD_NIBBLES;

	// Width of the conversion step counter (counts up to NUMBER_W).
	localparam int STEP_W = 6;

	// Width of one emitted character code.
	localparam int CODE_W = 6;

	// Character codes.
	localparam logic [CODE_W-1:0] ASCII_ZERO = 6'h30;
	localparam logic [CODE_W-1:0] TERMINATOR = 6'h00;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Add three to every nibble of five or more, ahead of the next shift.
	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] r;
		r = v;
		for (int i = 0; i < BCD_NIBBLES; i++) begin
			if (v[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = v[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/b2a_front.sv =====
// Front part: accepts a request and converts it to packed BCD by double dabble.
module b2a_front #(
	parameter int DIGIT_COUNT = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [b2a_pkg::NUMBER_W-1:0]        number,
	output logic                                push_valid,
	input  logic                                push_ready,
	output logic [4*DIGIT_COUNT-1:0]            push_digits
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]                     state_q;
	logic [b2a_pkg::STEP_W-1:0]     step_q;
	logic [b2a_pkg::NUMBER_W-1:0]   shift_q;
	logic [b2a_pkg::BCD_W-1:0]      bcd_q;
	logic [b2a_pkg::BCD_W-1:0]      bcd_adj;
	logic                           last_step;

	// Only the lowest digits are passed on, which also takes the value modulo 10^DIGIT_COUNT.
	assign busy        = (state_q != ST_IDLE);
	assign push_valid  = (state_q == ST_HOLD);
	assign push_digits = bcd_q[4*DIGIT_COUNT-1:0];
	assign bcd_adj     = b2a_pkg::bcd_adjust(bcd_q);
	assign last_step   = (step_q == b2a_pkg::STEP_W'(b2a_pkg::NUMBER_W - 1));

	// Control sequence: idle, one step per input bit, then hold until the queue takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
						step_q  <= '0;
					end
				end
				ST_CONV: begin
					step_q <= step_q + 1'b1;
					if (last_step) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: load the number, then adjust and shift one bit into the BCD word per step.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			shift_q <= number;
			bcd_q   <= '0;
		end else if (state_q == ST_CONV) begin
			shift_q <= {shift_q[b2a_pkg::NUMBER_W-2:0], 1'b0};
			bcd_q   <= {bcd_adj[b2a_pkg::BCD_W-2:0], shift_q[b2a_pkg::NUMBER_W-1]};
		end
	end

endmodule

// ===== rtl/b2a_queue.sv =====
// Short queue of converted digit words between the front and the back.
module b2a_queue #(
	parameter int WIDTH = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0]            entries_q [b2a_pkg::QUEUE_DEPTH];
	logic [b2a_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [b2a_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [b2a_pkg::QCNT_W-1:0]  count_q;
	logic                        do_wr;
	logic                        do_rd;

	assign wr_ready = (count_q != b2a_pkg::QCNT_W'(b2a_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entries_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				if (wr_ptr_q == b2a_pkg::QPTR_W'(b2a_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_rd) begin
				if (rd_ptr_q == b2a_pkg::QPTR_W'(b2a_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/b2a_back.sv =====
// Back part: emits the queued digits as ASCII characters, then the terminator.
module b2a_back #(
	parameter int DIGIT_COUNT = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  logic [4*DIGIT_COUNT-1:0]      pop_digits,
	output logic                          strobe,
	output logic [b2a_pkg::CODE_W-1:0]    char_code,
	output logic                          last
);

	localparam int IDX_W = $clog2(DIGIT_COUNT + 1);

	logic                          emitting_q;
	logic [IDX_W-1:0]              idx_q;
	logic [4*DIGIT_COUNT-1:0]      digits_q;
	logic                          strobe_q;
	logic                          last_q;
	logic [b2a_pkg::CODE_W-1:0]    code_q;
	logic                          at_term;

	assign pop_ready = !emitting_q;
	assign at_term   = (idx_q == IDX_W'(DIGIT_COUNT));
	assign strobe    = strobe_q;
	assign last      = last_q;
	assign char_code = code_q;

	// Emit sequence: one character per cycle, the terminator after the last digit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitting_q <= 1'b0;
			idx_q      <= '0;
			strobe_q   <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			strobe_q <= emitting_q;
			last_q   <= emitting_q && at_term;
			if (emitting_q) begin
				idx_q <= idx_q + 1'b1;
				if (at_term) begin
					emitting_q <= 1'b0;
				end
			end else if (pop_valid) begin
				emitting_q <= 1'b1;
				idx_q      <= '0;
			end
		end
	end

	// Digit word and character register; the most significant nibble goes out first.
	always_ff @(posedge clk) begin
		if (emitting_q) begin
			digits_q <= digits_q << 4;
			if (at_term) begin
				code_q <= b2a_pkg::TERMINATOR;
			end else begin
				code_q <= b2a_pkg::ASCII_ZERO + {2'b00, digits_q[4*DIGIT_COUNT-1 -: 4]};
			end
		end else if (pop_valid) begin
			digits_q <= pop_digits;
		end
	end

endmodule

// ===== rtl/binary_to_ascii_decimal_digits_top.sv =====
// Top level of the binary to ASCII decimal digit converter.
//
// A request is a 40-bit unsigned number on number, taken at a clock edge where
// start is high and busy is low. For each request the block emits DIGIT_COUNT
// ASCII digits ('0' to '9') of the number modulo 10^DIGIT_COUNT, most
// significant first with leading zeros, and then a zero terminator marked by
// last. Each character is on char_code for one cycle with strobe high.
// The front converts by double dabble, one input bit per cycle, and stays busy
// through the shift steps and until the short queue takes the BCD word, so it
// takes no new request before it is through with the last one. The back drains
// the queue on its own and takes a new word only once it has emitted the last.
// The receiver cannot stall; results are simply presented once.
// Reset clears the control state and the queue; no clearing pass is needed.
module binary_to_ascii_decimal_digits_top #(
	parameter int DIGIT_COUNT = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [b2a_pkg::NUMBER_W-1:0]      number,
	output logic                              strobe,
	output logic [b2a_pkg::CODE_W-1:0]        char_code,
	output logic                              last
);

	logic                         push_valid;
	logic                         push_ready;
	logic [4*DIGIT_COUNT-1:0]     push_digits;
	logic                         pop_valid;
	logic                         pop_ready;
	logic [4*DIGIT_COUNT-1:0]     pop_digits;

	// Conversion front.
	b2a_front #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.number      (number),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_digits (push_digits)
	);

	// Queue of converted words.
	b2a_queue #(
		.WIDTH (4 * DIGIT_COUNT)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_digits),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_digits)
	);

	// Character emitter.
	b2a_back #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_digits (pop_digits),
		.strobe     (strobe),
		.char_code  (char_code),
		.last       (last)
	);

	// An accepted request keeps the front busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("front not busy after accepting a request");

	// The last mark only ever comes with a strobe, and carries the terminator.
	assert property (@(posedge clk) disable iff (!arst_n)
		last |-> (strobe && char_code == b2a_pkg::TERMINATOR))
		else $error("last without strobe or with a non-terminator code");

	// Every other strobed character is a decimal digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> (char_code >= b2a_pkg::ASCII_ZERO &&
			char_code <= b2a_pkg::ASCII_ZERO + 6'd9))
		else $error("emitted character is not a decimal digit");

	// The back never pops while it is still emitting a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> !pop_ready)
		else $error("back accepted a second word while emitting");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the binary to ASCII decimal digit converter.
`timescale 1ns / 1ps

module tb;

	localparam int DIGITS = 12;
	localparam longint unsigned TEN_POW_DIGITS = 64'd1000000000000;
	localparam longint unsigned NUMBER_MAX = 64'hFF_FFFF_FFFF;
	localparam int RANDOM_REQUESTS = 410;
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT = 1000;

	// One emitted character as the receiver sees it.
	typedef struct packed {
		logic [b2a_pkg::CODE_W-1:0] code;
		logic                       last;
	} char_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic [b2a_pkg::NUMBER_W-1:0] number = '0;
	logic                         busy;
	logic                         strobe;
	logic [b2a_pkg::CODE_W-1:0]   char_code;
	logic                         last;

	logic [b2a_pkg::NUMBER_W-1:0] pending_numbers[$];
	char_result_t        expected_chars[$];
	char_result_t        oldest_char;
	int                  requests_taken = 0;
	int                  failures = 0;
	int                  stall_cycles = 0;
	int                  sender_idle_pct;
	bit                  accepted;

	binary_to_ascii_decimal_digits_top #(
		.DIGIT_COUNT(DIGITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.number(number),
		.strobe(strobe),
		.char_code(char_code),
		.last(last)
	);

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Queue the characters expected for one request: the low twelve decimal
	// digits, most significant first, then the terminator.
	task automatic queue_decimal_chars(input logic [b2a_pkg::NUMBER_W-1:0] value);
		longint unsigned reduced;
		logic [3:0]      digit[DIGITS];
		char_result_t    item;
		reduced = longint'(value) % TEN_POW_DIGITS;
		for (int i = DIGITS - 1; i >= 0; i--) begin
			digit[i] = 4'(reduced % 10);
			reduced = reduced / 10;
		end
		for (int i = 0; i < DIGITS; i++) begin
			item.code = b2a_pkg::ASCII_ZERO + b2a_pkg::CODE_W'(digit[i]);
			item.last = 1'b0;
			expected_chars.push_back(item);
		end
		item.code = b2a_pkg::TERMINATOR;
		item.last = 1'b1;
		expected_chars.push_back(item);
	endtask

	// Random number, weighted towards the wrap point and the edges of the field.
	function automatic logic [b2a_pkg::NUMBER_W-1:0] random_number();
		longint unsigned raw;
		int unsigned     pick;
		raw = {$urandom(), $urandom()};
		pick = $urandom_range(99, 0);
		if (pick < 40) begin
			return raw[b2a_pkg::NUMBER_W-1:0];
		end else if (pick < 60) begin
			return b2a_pkg::NUMBER_W'(TEN_POW_DIGITS - 500 + raw % 1001);
		end else if (pick < 72) begin
			return b2a_pkg::NUMBER_W'(NUMBER_MAX - raw % 1000);
		end else if (pick < 85) begin
			return b2a_pkg::NUMBER_W'(raw % 100000);
		end else begin
			return b2a_pkg::NUMBER_W'(raw % TEN_POW_DIGITS);
		end
	endfunction

	// Request driver: takes the next pending number, holds it until accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			accepted = start && !busy;
			if (accepted) begin
				queue_decimal_chars(number);
				void'(pending_numbers.pop_front());
				requests_taken++;
			end
			sender_idle_pct = (requests_taken < 150) ? 15 : (requests_taken < 300) ? 67 : 0;
			if (start && !accepted) begin
				// Request still waiting; start and number stay as they are.
			end else if (pending_numbers.size() != 0 &&
					$urandom_range(99, 0) >= sender_idle_pct) begin
				start <= 1'b1;
				number <= pending_numbers[0];
			end else begin
				start <= 1'b0;
				number <= random_number();
			end
		end
	end

	// Character monitor: compares each strobed character with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected character: got code %0d last %0d",
					$time, char_code, last);
				failures++;
			end else begin
				oldest_char = expected_chars.pop_front();
				if (char_code !== oldest_char.code) begin
					$display("%0t: char_code mismatch: expected %0d, got %0d",
						$time, oldest_char.code, char_code);
					failures++;
				end
				if (last !== oldest_char.last) begin
					$display("%0t: last mismatch: expected %0d, got %0d",
						$time, oldest_char.last, last);
					failures++;
				end
			end
		end
	end

	// Watchdog: ends the run when neither a request nor a character moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout with %0d requests and %0d characters outstanding",
				$time, pending_numbers.size(), expected_chars.size());
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		// Directed numbers: zero, digit boundaries, the wrap point and field extremes.
		pending_numbers.push_back(40'd0);
		pending_numbers.push_back(40'd1);
		pending_numbers.push_back(40'd9);
		pending_numbers.push_back(40'd10);
		pending_numbers.push_back(40'd99);
		pending_numbers.push_back(40'd100);
		pending_numbers.push_back(40'd100000000000);
		pending_numbers.push_back(40'd499999999999);
		pending_numbers.push_back(40'd555555555555);
		pending_numbers.push_back(40'd999999999999);
		pending_numbers.push_back(40'd1000000000000);
		pending_numbers.push_back(40'd1000000000001);
		pending_numbers.push_back(40'd1000123456789);
		pending_numbers.push_back(40'd123456789012);
		pending_numbers.push_back(40'd987654321098);
		pending_numbers.push_back(40'h80_0000_0000);
		pending_numbers.push_back(40'h55_5555_5555);
		pending_numbers.push_back(40'hAA_AAAA_AAAA);
		pending_numbers.push_back(40'hFF_FFFF_FFFE);
		pending_numbers.push_back(40'hFF_FFFF_FFFF);
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			pending_numbers.push_back(random_number());
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_numbers.size() != 0 || expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_chars.size() != 0) begin
			$display("%0t: %0d expected characters never arrived",
				$time, expected_chars.size());
			failures++;
		end
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/b2a_pkg.sv
rtl/b2a_front.sv
rtl/b2a_queue.sv
rtl/b2a_back.sv
rtl/binary_to_ascii_decimal_digits_top.sv
tb/tb.sv
